// ----- rtl/itbs_pkg.sv -----
// ----------------------------------------------------------------------------
// itbs_pkg
// Shared widths, character constants, register codes, state and status types
// for the integer-to-symbol-string converter.
// ----------------------------------------------------------------------------
package itbs_pkg;

  // Default symbol table size
  localparam int unsigned MAX_SYMBOLS_DEF = 16;

  // Field widths
  localparam int unsigned NUM_W        = 32;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned LEN_W        = 5;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned SYM_PER_WORD = CFG_DATA_W / CHAR_W;

  // Byte-serial divider: one byte of the dividend per cycle
  localparam int unsigned BYTES_PER_NUM = NUM_W / CHAR_W;
  localparam int unsigned BYTE_CNT_W    = $clog2(BYTES_PER_NUM);
  localparam logic [BYTE_CNT_W-1:0] BYTE_CNT_LAST = BYTE_CNT_W'(BYTES_PER_NUM - 1);

  // Digit stack: a 32-bit magnitude has at most 32 digits (radix 2)
  localparam int unsigned DIG_DEPTH = NUM_W;
  localparam int unsigned DIG_CNT_W = $clog2(DIG_DEPTH + 1);
  localparam int unsigned DIG_PTR_W = $clog2(DIG_DEPTH);

  // Characters that may not appear in the symbol table
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_LENGTH  = 2'd0,
    CFG_SYMBOLS_LOW  = 2'd1,
    CFG_SYMBOLS_HIGH = 2'd2
  } cfg_reg_e;

  // Main sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } itbs_state_e;

  // Table checker status
  typedef struct packed {
    logic done;
    logic valid;
  } chk_stat_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic digit_valid;
    logic last_digit;
  } div_stat_t;

  // Digit stack status
  typedef struct packed {
    logic empty;
    logic one;
  } lifo_stat_t;

endpackage

// ----- rtl/itbs_num_if.sv -----
// ----------------------------------------------------------------------------
// itbs_num_if
// Input channel: one signed number per item.
// ----------------------------------------------------------------------------
interface itbs_num_if;
  logic                              valid;
  logic                              ready;
  logic signed [itbs_pkg::NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

// ----- rtl/itbs_chr_if.sv -----
// ----------------------------------------------------------------------------
// itbs_chr_if
// Output channel: one character per item, with a flag on the final one.
// ----------------------------------------------------------------------------
interface itbs_chr_if;
  logic                         valid;
  logic                         ready;
  logic [itbs_pkg::CHAR_W-1:0]  character;
  logic                         last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- rtl/itbs_cfg_if.sv -----
// ----------------------------------------------------------------------------
// itbs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface itbs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [itbs_pkg::CFG_IDX_W-1:0]   index;
  logic [itbs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/itbs_table_check.sv -----
// ----------------------------------------------------------------------------
// itbs_table_check
// Symbol table validator. Copies the table into a byte shift register and
// examines one symbol per cycle against the bad-character list and against
// every later symbol still in use.
// ----------------------------------------------------------------------------
module itbs_table_check #(
  parameter int unsigned MAX_SYMBOLS = itbs_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             start_i,
  input  logic [itbs_pkg::LEN_W-1:0]                       len_i,
  input  logic [MAX_SYMBOLS-1:0][itbs_pkg::CHAR_W-1:0]     sym_i,
  output itbs_pkg::chk_stat_t                              stat_o
);

  localparam int unsigned LW = $clog2(MAX_SYMBOLS + 1);

  logic                                         busy_q;
  logic                                         bad_q;
  logic                                         done_q;
  logic                                         valid_q;
  logic [LW-1:0]                                left_q;
  logic [MAX_SYMBOLS-1:0][itbs_pkg::CHAR_W-1:0] sh_q;

  logic                          len_ok;
  logic [itbs_pkg::CHAR_W-1:0]   cur;
  logic                          char_bad;
  logic                          dup;
  logic                          bad_d;

  // Length must lie in 2..MAX_SYMBOLS
  assign len_ok = (len_i >= itbs_pkg::LEN_W'(2)) &&
                  (len_i <= itbs_pkg::LEN_W'(MAX_SYMBOLS));

  // Examine the symbol at the head of the shift register
  always_comb begin
    cur      = sh_q[0];
    char_bad = (cur == itbs_pkg::CH_PLUS) || (cur == itbs_pkg::CH_MINUS) ||
               (cur <= itbs_pkg::CH_SPACE) || (cur >= itbs_pkg::CH_DEL);
    dup      = 1'b0;
    for (int j = 1; j < MAX_SYMBOLS; j++) begin
      if ((LW'(j) < left_q) && (sh_q[j] == cur)) begin
        dup = 1'b1;
      end
    end
    bad_d = bad_q | char_bad | dup;
  end

  // Control: start, count down the symbols in use, report once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (len_ok) begin
          busy_q <= 1'b1;
        end else begin
          done_q  <= 1'b1;
          valid_q <= 1'b0;
        end
      end else if (busy_q && (left_q == LW'(1))) begin
        busy_q  <= 1'b0;
        done_q  <= 1'b1;
        valid_q <= !bad_d;
      end
    end
  end

  // Payload: load the table, shift one symbol out per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q   <= sym_i;
      left_q <= LW'(len_i);
      bad_q  <= 1'b0;
    end else if (busy_q) begin
      sh_q   <= {itbs_pkg::CHAR_W'(0), sh_q[MAX_SYMBOLS-1:1]};
      left_q <= left_q - LW'(1);
      bad_q  <= bad_d;
    end
  end

  assign stat_o.done  = done_q;
  assign stat_o.valid = valid_q;

endmodule

// ----- rtl/itbs_div_unit.sv -----
// ----------------------------------------------------------------------------
// itbs_div_unit
// Byte-serial divider by a small radix. The dividend sits in a shift register;
// each cycle the top byte is divided with the running remainder and the
// quotient byte enters at the bottom. After one pass the remainder is the
// next digit, and passes repeat until the quotient is zero.
// ----------------------------------------------------------------------------
module itbs_div_unit #(
  parameter int unsigned MAX_SYMBOLS = itbs_pkg::MAX_SYMBOLS_DEF,
  parameter int unsigned DW          = $clog2(MAX_SYMBOLS),
  parameter int unsigned RW          = $clog2(MAX_SYMBOLS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [itbs_pkg::NUM_W-1:0]    dividend_i,
  input  logic [RW-1:0]                 divisor_i,
  output itbs_pkg::div_stat_t           stat_o,
  output logic [DW-1:0]                 digit_o
);

  logic                                busy_q;
  logic [itbs_pkg::BYTE_CNT_W-1:0]     cnt_q;
  logic [itbs_pkg::NUM_W-1:0]          quo_q;
  logic [DW-1:0]                       rem_q;
  logic                                nz_q;
  logic [RW-1:0]                       div_q;

  logic [DW-1:0]                       r;
  logic [DW:0]                         x;
  logic [itbs_pkg::CHAR_W-1:0]         q8;
  logic                                nz_next;
  logic                                pass_end;

  // Divide remainder:top byte by the radix, one restoring step per bit
  always_comb begin
    r  = rem_q;
    x  = '0;
    q8 = '0;
    for (int t = itbs_pkg::CHAR_W - 1; t >= 0; t--) begin
      x = {r, quo_q[itbs_pkg::NUM_W - itbs_pkg::CHAR_W + t]};
      if (x >= (DW+1)'(div_q)) begin
        x     = x - (DW+1)'(div_q);
        q8[t] = 1'b1;
      end
      r = x[DW-1:0];
    end
    nz_next  = nz_q | (|q8);
    pass_end = busy_q && (cnt_q == itbs_pkg::BYTE_CNT_LAST);
  end

  // Control: byte counter and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + itbs_pkg::BYTE_CNT_W'(1);
      if (pass_end && !nz_next) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: rotate quotient bytes in, restart remainder after each pass
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      nz_q  <= 1'b0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[itbs_pkg::NUM_W-itbs_pkg::CHAR_W-1:0], q8};
      if (pass_end) begin
        rem_q <= '0;
        nz_q  <= 1'b0;
      end else begin
        rem_q <= r;
        nz_q  <= nz_next;
      end
    end
  end

  assign stat_o.busy        = busy_q;
  assign stat_o.digit_valid = pass_end;
  assign stat_o.last_digit  = pass_end && !nz_next;
  assign digit_o            = r;

endmodule

// ----- rtl/itbs_digit_lifo.sv -----
// ----------------------------------------------------------------------------
// itbs_digit_lifo
// Digit stack. Digits arrive least significant first and leave most
// significant first.
// ----------------------------------------------------------------------------
module itbs_digit_lifo #(
  parameter int unsigned MAX_SYMBOLS = itbs_pkg::MAX_SYMBOLS_DEF,
  parameter int unsigned DW          = $clog2(MAX_SYMBOLS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [DW-1:0]         push_digit_i,
  input  logic                  pop_i,
  output logic [DW-1:0]         top_o,
  output itbs_pkg::lifo_stat_t  stat_o
);

  logic [itbs_pkg::DIG_CNT_W-1:0] cnt_q;
  logic [itbs_pkg::DIG_CNT_W-1:0] cnt_m1;
  logic [DW-1:0]                  mem_q [itbs_pkg::DIG_DEPTH];

  assign cnt_m1 = cnt_q - itbs_pkg::DIG_CNT_W'(1);

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (push_i) begin
      cnt_q <= cnt_q + itbs_pkg::DIG_CNT_W'(1);
    end else if (pop_i) begin
      cnt_q <= cnt_m1;
    end
  end

  // Store digits
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[cnt_q[itbs_pkg::DIG_PTR_W-1:0]] <= push_digit_i;
    end
  end

  assign top_o        = mem_q[cnt_m1[itbs_pkg::DIG_PTR_W-1:0]];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.one   = (cnt_q == itbs_pkg::DIG_CNT_W'(1));

endmodule

// ----- rtl/integer_to_base_symbols_core.sv -----
// ----------------------------------------------------------------------------
// integer_to_base_symbols_core
// Converts a signed 32-bit number to a string of symbols in the radix set by
// the configured symbol table: '-' first for a negative number, then the
// digits most significant first, last set on the final character. A table
// with a length outside 2..MAX_SYMBOLS, a repeated symbol, or a symbol that is
// '+', '-', 32 or below, or 127 and above is rejected and the number gives no
// characters. One number is in work at a time. After acceptance the table
// checker examines the table, then the byte-serial divider works out the digits
// (one byte of the 32-bit magnitude per cycle), and the characters leave at
// one per cycle from an output register while the output is not stalled, the
// sign already during the division. The next number is taken as soon as the
// final character sits in the output register.
// ----------------------------------------------------------------------------
module integer_to_base_symbols_core #(
  parameter int unsigned MAX_SYMBOLS = itbs_pkg::MAX_SYMBOLS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itbs_num_if.sink    num_i,
  itbs_chr_if.source  chr_o,
  itbs_cfg_if.sink    cfg_i
);

  localparam int unsigned DW = $clog2(MAX_SYMBOLS);
  localparam int unsigned RW = $clog2(MAX_SYMBOLS + 1);

  // Configuration registers
  logic [itbs_pkg::LEN_W-1:0]                   sym_cnt_q;
  logic [MAX_SYMBOLS-1:0][itbs_pkg::CHAR_W-1:0] sym_q;

  // Sequencer
  itbs_pkg::itbs_state_e         state_q, state_d;
  logic                          neg_q;
  logic [itbs_pkg::NUM_W-1:0]    mag_q;
  logic                          sign_pend_q;

  // Output register
  logic                          out_valid_q;
  logic [itbs_pkg::CHAR_W-1:0]   chr_q;
  logic                          last_q;

  // Unit connections
  itbs_pkg::chk_stat_t           chk_stat;
  itbs_pkg::div_stat_t           div_stat;
  itbs_pkg::lifo_stat_t          lifo_stat;
  logic [DW-1:0]                 div_digit;
  logic [DW-1:0]                 lifo_top;

  logic                          in_acc;
  logic                          cfg_acc;
  logic                          div_start;
  logic                          out_free;
  logic                          load_sign;
  logic                          load_dig;

  assign num_i.ready = (state_q == itbs_pkg::ST_IDLE);
  assign in_acc      = num_i.valid && num_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_cnt_q <= '0;
      sym_q     <= '0;
    end else if (cfg_acc) begin
      unique case (itbs_pkg::cfg_reg_e'(cfg_i.index))
        itbs_pkg::CFG_BASE_LENGTH: begin
          sym_cnt_q <= cfg_i.data[itbs_pkg::LEN_W-1:0];
        end
        itbs_pkg::CFG_SYMBOLS_LOW: begin
          for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (i < itbs_pkg::SYM_PER_WORD) begin
              sym_q[i] <= cfg_i.data[i*itbs_pkg::CHAR_W +: itbs_pkg::CHAR_W];
            end
          end
        end
        itbs_pkg::CFG_SYMBOLS_HIGH: begin
          for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (i >= itbs_pkg::SYM_PER_WORD) begin
              sym_q[i] <= cfg_i.data[(i-itbs_pkg::SYM_PER_WORD)*itbs_pkg::CHAR_W +:
                                     itbs_pkg::CHAR_W];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Table checker
  itbs_table_check #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .len_i   (sym_cnt_q),
    .sym_i   (sym_q),
    .stat_o  (chk_stat)
  );

  assign div_start = (state_q == itbs_pkg::ST_CHECK) && chk_stat.done && chk_stat.valid;

  // Digit generator
  itbs_div_unit #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .DW          (DW),
    .RW          (RW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_q),
    .divisor_i  (RW'(sym_cnt_q)),
    .stat_o     (div_stat),
    .digit_o    (div_digit)
  );

  // Digit stack
  itbs_digit_lifo #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .DW          (DW)
  ) u_lifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (div_stat.digit_valid),
    .push_digit_i (div_digit),
    .pop_i        (load_dig),
    .top_o        (lifo_top),
    .stat_o       (lifo_stat)
  );

  // Output register loads: sign first, digits once division is done
  always_comb begin
    out_free  = !out_valid_q || chr_o.ready;
    load_sign = out_free && sign_pend_q &&
                ((state_q == itbs_pkg::ST_DIV) || (state_q == itbs_pkg::ST_EMIT));
    load_dig  = out_free && !sign_pend_q && (state_q == itbs_pkg::ST_EMIT) &&
                !lifo_stat.empty;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itbs_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = itbs_pkg::ST_CHECK;
        end
      end
      itbs_pkg::ST_CHECK: begin
        if (chk_stat.done) begin
          state_d = chk_stat.valid ? itbs_pkg::ST_DIV : itbs_pkg::ST_IDLE;
        end
      end
      itbs_pkg::ST_DIV: begin
        if (div_stat.last_digit) begin
          state_d = itbs_pkg::ST_EMIT;
        end
      end
      itbs_pkg::ST_EMIT: begin
        if (load_dig && lifo_stat.one) begin
          state_d = itbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = itbs_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold state and sign request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itbs_pkg::ST_IDLE;
      sign_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_start) begin
        sign_pend_q <= neg_q;
      end else if (load_sign) begin
        sign_pend_q <= 1'b0;
      end
    end
  end

  // Capture sign and magnitude of the accepted item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      neg_q <= num_i.number[itbs_pkg::NUM_W-1];
      mag_q <= num_i.number[itbs_pkg::NUM_W-1] ? (~num_i.number + itbs_pkg::NUM_W'(1))
                                               : num_i.number;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_sign || load_dig) begin
      out_valid_q <= 1'b1;
    end else if (chr_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (load_sign) begin
      chr_q  <= itbs_pkg::CH_MINUS;
      last_q <= 1'b0;
    end else if (load_dig) begin
      chr_q  <= sym_q[lifo_top];
      last_q <= lifo_stat.one;
    end
  end

  assign chr_o.valid     = out_valid_q;
  assign chr_o.character = chr_q;
  assign chr_o.last      = last_q;

  // Stack drains fully before the next item
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == itbs_pkg::ST_IDLE) |-> lifo_stat.empty)
    else $error("digit stack not empty in idle");

  // Divider runs only in the divide state
  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == itbs_pkg::ST_DIV))
    else $error("divider busy outside divide state");

  // A sign character never ends a string
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (chr_q == itbs_pkg::CH_MINUS)) |-> !last_q)
    else $error("sign flagged as last character");

  // Final digit returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_dig && lifo_stat.one) |=> (state_q == itbs_pkg::ST_IDLE))
    else $error("sequencer not idle after final digit");

endmodule

// ----- bench/itbs_spelling_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// itbs_spelling_check
// Watches the number, character and configuration channels of the converter.
// Keeps its own copy of the symbol table registers, spells every accepted
// number into the characters it must produce, and compares each character
// that leaves the block against the oldest one still due.
// ----------------------------------------------------------------------------
module itbs_spelling_check #(
  parameter int unsigned MAX_SYMBOLS = itbs_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             num_valid_i,
  input  logic                             num_ready_i,
  input  logic signed [itbs_pkg::NUM_W-1:0] number_i,
  input  logic                             chr_valid_i,
  input  logic                             chr_ready_i,
  input  logic [itbs_pkg::CHAR_W-1:0]      character_i,
  input  logic                             last_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [itbs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [itbs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int unsigned                      chars_due_o,
  output int unsigned                      mismatches_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [itbs_pkg::CHAR_W-1:0] character;
    logic                        last;
  } text_char_t;

  // Shadow of the configuration registers
  logic [itbs_pkg::LEN_W-1:0]      sym_cnt;
  logic [itbs_pkg::CFG_DATA_W-1:0] sym_lo;
  logic [itbs_pkg::CFG_DATA_W-1:0] sym_hi;

  // Characters still owed by the block, oldest first
  text_char_t expected_text[$];
  text_char_t want;

  function automatic logic [itbs_pkg::CHAR_W-1:0] symbol_of(input int unsigned idx);
    logic [2*itbs_pkg::CFG_DATA_W-1:0] table_bits;
    table_bits = {sym_hi, sym_lo};
    return table_bits[idx*itbs_pkg::CHAR_W +: itbs_pkg::CHAR_W];
  endfunction

  // Spell one number with the current table; a rejected table owes nothing
  task automatic spell_number(input logic signed [itbs_pkg::NUM_W-1:0] value);
    int unsigned                 radix;
    int unsigned                 i;
    int unsigned                 j;
    logic [itbs_pkg::NUM_W:0]    magnitude;
    logic [itbs_pkg::CHAR_W-1:0] sym;
    int unsigned                 digits[$];
    radix = sym_cnt;
    if (radix < 2 || radix > MAX_SYMBOLS) return;
    for (i = 0; i < radix; i++) begin
      sym = symbol_of(i);
      if (sym == itbs_pkg::CH_PLUS || sym == itbs_pkg::CH_MINUS ||
          sym <= itbs_pkg::CH_SPACE || sym >= itbs_pkg::CH_DEL) return;
      for (j = i + 1; j < radix; j++) begin
        if (sym == symbol_of(j)) return;
      end
    end
    // take the magnitude one bit wider so the most negative value survives
    if (value[itbs_pkg::NUM_W-1]) begin
      magnitude = '0 - {value[itbs_pkg::NUM_W-1], value};
      expected_text.push_back(text_char_t'{character: itbs_pkg::CH_MINUS, last: 1'b0});
    end else begin
      magnitude = {1'b0, value};
    end
    do begin
      digits.push_front(32'(magnitude % radix));
      magnitude = magnitude / radix;
    end while (magnitude != 0);
    for (i = 0; i < digits.size(); i++) begin
      expected_text.push_back(text_char_t'{character: symbol_of(digits[i]),
                                           last: (i + 1 == digits.size())});
    end
  endtask

  // Track writes, predict on accepted numbers, compare accepted characters
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_cnt = '0;
      sym_lo = '0;
      sym_hi = '0;
      expected_text.delete();
      chars_due_o = 0;
      mismatches_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          itbs_pkg::CFG_BASE_LENGTH:  sym_cnt = cfg_data_i[itbs_pkg::LEN_W-1:0];
          itbs_pkg::CFG_SYMBOLS_LOW:  sym_lo = cfg_data_i;
          itbs_pkg::CFG_SYMBOLS_HIGH: sym_hi = cfg_data_i;
          default:                    ;
        endcase
      end
      if (num_valid_i && num_ready_i) begin
        spell_number(number_i);
      end
      if (chr_valid_i && chr_ready_i) begin
        if (expected_text.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= REPORT_LIMIT) begin
            $display("%0t: character %h last %b arrived with nothing due",
                     $time, character_i, last_i);
          end
        end else begin
          want = expected_text.pop_front();
          if (want.character !== character_i || want.last !== last_i) begin
            mismatches_o++;
            if (mismatches_o <= REPORT_LIMIT) begin
              $display("%0t: expected character %h last %b, got character %h last %b",
                       $time, want.character, want.last, character_i, last_i);
            end
          end
        end
      end
      chars_due_o = expected_text.size();
    end
  end

endmodule

// ----- bench/integer_to_base_symbols_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_base_symbols_core_test
// Drives numbers and symbol tables into the converter with random gaps and
// stalls on both channels. Covers decimal, binary and full 16-symbol tables,
// the extreme numbers, and every kind of rejected table, then runs random
// tables with random numbers. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module integer_to_base_symbols_core_test;

  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned RANDOM_ITEMS = 400;

  // Index with no register behind it
  localparam logic [itbs_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  // Tables: "01234567", "89" with junk above, "89ABCDEF", and "!~" for binary
  localparam logic [itbs_pkg::CFG_DATA_W-1:0] DEC_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [itbs_pkg::CFG_DATA_W-1:0] DEC_HIGH = 64'hFFFF_FFFF_FFFF_3938;
  localparam logic [itbs_pkg::CFG_DATA_W-1:0] HEX_HIGH = 64'h4645_4443_4241_3938;
  localparam logic [itbs_pkg::CFG_DATA_W-1:0] BIN_LOW  = 64'h0000_0000_0000_7E21;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  itbs_num_if num_if ();
  itbs_chr_if chr_if ();
  itbs_cfg_if cfg_if ();

  int unsigned chars_due;
  int unsigned mismatches;
  bit          tx_quiet;
  bit          rx_quiet;
  int unsigned hold_request;
  int unsigned scored_items;

  integer_to_base_symbols_core #(
    .MAX_SYMBOLS(itbs_pkg::MAX_SYMBOLS_DEF)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .num_i  (num_if),
    .chr_o  (chr_if),
    .cfg_i  (cfg_if)
  );

  itbs_spelling_check #(
    .MAX_SYMBOLS(itbs_pkg::MAX_SYMBOLS_DEF)
  ) spelling_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .num_valid_i  (num_if.valid),
    .num_ready_i  (num_if.ready),
    .number_i     (num_if.number),
    .chr_valid_i  (chr_if.valid),
    .chr_ready_i  (chr_if.ready),
    .character_i  (chr_if.character),
    .last_i       (chr_if.last),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_i  (cfg_if.ready),
    .cfg_index_i  (cfg_if.index),
    .cfg_data_i   (cfg_if.data),
    .chars_due_o  (chars_due),
    .mismatches_o (mismatches)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #50_000_000;
    $display("FAIL integer_to_base_symbols_core");
    $finish;
  end

  // Character sink: random stall per item, or one long hold when asked
  initial begin : receiver
    int unsigned stall;
    chr_if.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if (rx_quiet) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 13);
      end
      if (stall != 0) begin
        chr_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      chr_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!chr_if.valid) @(posedge clk_i);
    end
  end

  function automatic logic signed [itbs_pkg::NUM_W-1:0] draw_number();
    logic [itbs_pkg::NUM_W-1:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 5))
      0: return itbs_pkg::NUM_W'($urandom_range(0, 40));
      1: return itbs_pkg::NUM_W'(0) - itbs_pkg::NUM_W'($urandom_range(1, 40));
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h8000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      3: begin
        raw = raw >> $urandom_range(1, 31);
        return ($urandom_range(0, 1) == 1) ? raw : itbs_pkg::NUM_W'(0) - raw;
      end
      default: return raw;
    endcase
  endfunction

  // Legal table of the given radix; unused slots hold random bytes
  function automatic logic [2*itbs_pkg::CFG_DATA_W-1:0] make_table(
      input int unsigned radix);
    logic [2*itbs_pkg::CFG_DATA_W-1:0] bytes;
    logic [itbs_pkg::CHAR_W-1:0]       pick;
    bit                                taken[256];
    int unsigned                       i;
    bytes = {$urandom, $urandom, $urandom, $urandom};
    for (i = 0; i < radix; i++) begin
      do begin
        pick = itbs_pkg::CHAR_W'($urandom_range(33, 126));
      end while (pick == itbs_pkg::CH_PLUS || pick == itbs_pkg::CH_MINUS || taken[pick]);
      taken[pick] = 1'b1;
      bytes[i*itbs_pkg::CHAR_W +: itbs_pkg::CHAR_W] = pick;
    end
    return bytes;
  endfunction

  task automatic send_number(input logic signed [itbs_pkg::NUM_W-1:0] value);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      num_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    num_if.valid  <= 1'b1;
    num_if.number <= value;
    @(posedge clk_i);
    while (!num_if.ready) @(posedge clk_i);
  endtask

  // Drop the input, wait for every due character, then let the block go quiet
  task automatic settle();
    num_if.valid <= 1'b0;
    @(posedge clk_i);
    while (chars_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [itbs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [itbs_pkg::CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic load_table(input logic [itbs_pkg::LEN_W-1:0] len,
                            input logic [itbs_pkg::CFG_DATA_W-1:0] low,
                            input logic [itbs_pkg::CFG_DATA_W-1:0] high,
                            input bit stray_write);
    settle();
    if (stray_write) begin
      write_reg(CFG_NO_REG, {$urandom, $urandom});
    end
    write_reg(itbs_pkg::CFG_BASE_LENGTH, itbs_pkg::CFG_DATA_W'(len));
    write_reg(itbs_pkg::CFG_SYMBOLS_LOW, low);
    write_reg(itbs_pkg::CFG_SYMBOLS_HIGH, high);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic try_bad_table(input logic [itbs_pkg::LEN_W-1:0] len,
                               input logic [itbs_pkg::CFG_DATA_W-1:0] low,
                               input logic [itbs_pkg::CFG_DATA_W-1:0] high);
    load_table(len, low, high, 1'b0);
    send_number(draw_number());
    send_number(draw_number());
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    logic [2*itbs_pkg::CFG_DATA_W-1:0] tbl_bits;
    logic [itbs_pkg::LEN_W-1:0]        len;
    logic [itbs_pkg::CHAR_W-1:0]       bad_char;
    int unsigned                       radix;
    int unsigned                       count;
    int unsigned                       pos;
    int unsigned                       src;
    int unsigned                       phase;
    bit                                corrupt;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    hold_request  = 0;
    scored_items  = 0;
    num_if.valid  = 1'b0;
    num_if.number = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = itbs_pkg::CFG_BASE_LENGTH;
    cfg_if.data   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table out of reset: numbers are taken but give no text
    send_number(0);
    send_number(-1);

    // Decimal, with a write to the unused index that must change nothing
    load_table(10, DEC_LOW, DEC_HIGH, 1'b1);
    send_number(0);
    send_number(1);
    send_number(-1);
    send_number(9);
    send_number(10);
    send_number(-10);
    send_number(32'sh7FFF_FFFF);
    send_number(32'sh8000_0000);
    send_number(1000000000);
    send_number(-999);

    // Binary on the lowest and highest legal bytes: longest strings
    load_table(2, BIN_LOW, '0, 1'b0);
    send_number(32'sh8000_0000);
    send_number(32'sh7FFF_FFFF);
    send_number(-1);
    send_number(0);
    send_number(5);

    // Full 16-symbol table
    load_table(16, DEC_LOW, HEX_HIGH, 1'b0);
    send_number(0);
    send_number(16);
    send_number(32'sh7FFF_FFFF);
    send_number(32'sh8000_0000);
    send_number(-16);
    send_number(32'sh89AB_CDEF);

    // Rejected tables: bad lengths, repeats, forbidden bytes incl. the last slot
    try_bad_table(0, DEC_LOW, HEX_HIGH);
    try_bad_table(1, DEC_LOW, HEX_HIGH);
    try_bad_table(17, DEC_LOW, HEX_HIGH);
    try_bad_table(31, DEC_LOW, HEX_HIGH);
    try_bad_table(16, DEC_LOW, 64'h3045_4443_4241_3938);
    try_bad_table(16, 64'h3736_3534_2B32_3130, HEX_HIGH);
    try_bad_table(10, 64'h3736_3534_3332_312D, DEC_HIGH);
    try_bad_table(10, 64'h3736_2034_3332_3130, DEC_HIGH);
    try_bad_table(16, DEC_LOW, 64'h4645_4443_4241_7F38);
    try_bad_table(16, 64'h3736_3534_3380_3130, HEX_HIGH);
    try_bad_table(16, DEC_LOW, 64'hFF45_4443_4241_3938);
    try_bad_table(2, '1, '1);

    // Random tables; one in six is broken on purpose
    phase = 0;
    while (scored_items < RANDOM_ITEMS) begin
      radix    = $urandom_range(2, itbs_pkg::MAX_SYMBOLS_DEF);
      tbl_bits = make_table(radix);
      len      = itbs_pkg::LEN_W'(radix);
      corrupt  = (phase != 0) && ($urandom_range(0, 5) == 0);
      if (corrupt) begin
        case ($urandom_range(0, 3))
          0: begin
            len = ($urandom_range(0, 1) == 1) ? itbs_pkg::LEN_W'($urandom_range(0, 1))
                                               : itbs_pkg::LEN_W'($urandom_range(17, 31));
          end
          1: begin
            pos = $urandom_range(1, radix - 1);
            src = $urandom_range(0, pos - 1);
            tbl_bits[pos*itbs_pkg::CHAR_W +: itbs_pkg::CHAR_W] =
              tbl_bits[src*itbs_pkg::CHAR_W +: itbs_pkg::CHAR_W];
          end
          default: begin
            case ($urandom_range(0, 4))
              0:       bad_char = itbs_pkg::CH_PLUS;
              1:       bad_char = itbs_pkg::CH_MINUS;
              2:       bad_char = itbs_pkg::CHAR_W'($urandom_range(0, 32));
              3:       bad_char = itbs_pkg::CH_DEL;
              default: bad_char = itbs_pkg::CHAR_W'($urandom_range(128, 255));
            endcase
            pos = ($urandom_range(0, 1) == 1) ? radix - 1 : $urandom_range(0, radix - 1);
            tbl_bits[pos*itbs_pkg::CHAR_W +: itbs_pkg::CHAR_W] = bad_char;
          end
        endcase
      end
      load_table(len, tbl_bits[itbs_pkg::CFG_DATA_W-1:0],
                 tbl_bits[2*itbs_pkg::CFG_DATA_W-1:itbs_pkg::CFG_DATA_W],
                 $urandom_range(0, 3) == 0);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      // hold the output off once while numbers keep coming
      if (phase == 0) begin
        hold_request = LONG_HOLD;
      end
      count = corrupt ? 3 : $urandom_range(8, 30);
      repeat (count) send_number(draw_number());
      if (!corrupt) begin
        scored_items += count;
      end
      phase++;
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS integer_to_base_symbols_core");
    end else begin
      $display("FAIL integer_to_base_symbols_core");
    end
    $finish;
  end

endmodule
